FILE: src/cts_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the cooperative task scheduler
package cts_pkg;

  localparam int MAX_TASKS_DEF = 8;
  localparam int TICK_W        = 64;
  localparam int PERIOD_W      = 32;
  localparam int HANDLE_W      = 8;
  localparam int SLOT_W        = 8;

  typedef enum logic [1:0] {
    OP_ADD      = 2'd0,
    OP_DELETE   = 2'd1,
    OP_TICK     = 2'd2,
    OP_DISPATCH = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_ADD = 2'd0,
    KIND_DEL = 2'd1,
    KIND_RUN = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_SCAN_END,
    ST_DEL_RD,
    ST_DEL_WR
  } state_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [TICK_W-1:0]   due_at;
    logic [PERIOD_W-1:0] period;
  } entry_t;

endpackage

FILE: src/cts_table_mem.sv
`timescale 1ns / 1ps
// task table memory: one write port, one registered read port
module cts_table_mem #(
  parameter int DEPTH  = cts_pkg::MAX_TASKS_DEF,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [ADDR_W-1:0]  wr_addr,
  input  cts_pkg::entry_t    wr_data,
  input  logic               rd_en,
  input  logic [ADDR_W-1:0]  rd_addr,
  output cts_pkg::entry_t    rd_data
);

  cts_pkg::entry_t mem [DEPTH];
  cts_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/cooperative_task_scheduler_core.sv
`timescale 1ns / 1ps
// top level of the cooperative task scheduler: control, tick counter and result register
//
//  chan | handshake           | fields (each a port with the channel prefix)
//  -----+---------------------+----------------------------------------------------------
//  in   | in_valid, in_stall  | opcode, task_handle, start_delay, repeat_period, delete_index
//  out  | out_valid, out_stall| reply_kind, slot_index, run_handle, accepted, last_of_run
//
// add, tick and a refused delete complete in the idle state; a delete that removes an entry
// copies each entry above the removed one down a slot, reading it and then writing it.
// dispatch reads each entry from the table memory in ST_SCAN_RD and tests, reschedules or
// drops it in ST_SCAN_EV, survivors packed down in place.
// rst_n (synchronous) clears the count and the tick counter; table contents need no reset.
// a stalled result register holds the scan at the next due entry; one due task is held back
// so the last result of a dispatch can be flagged.
module cooperative_task_scheduler_core #(
  parameter int MAX_TASKS = cts_pkg::MAX_TASKS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_task_handle,
  input  logic [31:0] in_start_delay,
  input  logic [31:0] in_repeat_period,
  input  logic [7:0]  in_delete_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_reply_kind,
  output logic [7:0]  out_slot_index,
  output logic [7:0]  out_run_handle,
  output logic        out_accepted,
  output logic        out_last_of_run
);

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TASKS);

  cts_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [cts_pkg::TICK_W-1:0] tick_r, tick_nxt;
  logic [CNT_W-1:0]  rd_r, rd_nxt;
  logic [CNT_W-1:0]  wr_r, wr_nxt;
  logic              pend_valid_r, pend_valid_nxt;
  logic [IDX_W-1:0]  pend_slot_r, pend_slot_nxt;
  logic [7:0]        pend_handle_r, pend_handle_nxt;

  logic              out_valid_r;
  logic [1:0]        out_kind_r;
  logic [7:0]        out_slot_r;
  logic [7:0]        out_handle_r;
  logic              out_acc_r;
  logic              out_last_r;

  // result push from the control logic
  logic              push;
  logic [1:0]        push_kind;
  logic [7:0]        push_slot;
  logic [7:0]        push_handle;
  logic              push_acc;
  logic              push_last;

  logic              mem_wr_en;
  logic [IDX_W-1:0]  mem_wr_addr;
  cts_pkg::entry_t   mem_wr_data;
  logic              mem_rd_en;
  logic [IDX_W-1:0]  mem_rd_addr;
  cts_pkg::entry_t   mem_rd_data;

  logic              out_free;
  logic              in_xfer;
  logic              due;
  logic              del_ok;
  logic [CNT_W-1:0]  rd_dec;

  cts_table_mem #(
    .DEPTH  (MAX_TASKS),
    .ADDR_W (IDX_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == cts_pkg::ST_IDLE) && out_free);
  assign in_xfer  = in_valid && !in_stall;
  assign due      = tick_r >= mem_rd_data.due_at;
  assign del_ok   = in_delete_index < 8'(count_r);
  assign rd_dec   = rd_r - CNT_W'(1);

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    tick_nxt        = tick_r;
    rd_nxt          = rd_r;
    wr_nxt          = wr_r;
    pend_valid_nxt  = pend_valid_r;
    pend_slot_nxt   = pend_slot_r;
    pend_handle_nxt = pend_handle_r;
    push            = 1'b0;
    push_kind       = cts_pkg::KIND_RUN;
    push_slot       = 8'(pend_slot_r);
    push_handle     = pend_handle_r;
    push_acc        = 1'b1;
    push_last       = 1'b0;
    mem_wr_en       = 1'b0;
    mem_wr_addr     = wr_r[IDX_W-1:0];
    mem_wr_data     = mem_rd_data;
    mem_rd_en       = 1'b0;
    mem_rd_addr     = rd_r[IDX_W-1:0];

    case (state_r)
      cts_pkg::ST_IDLE: begin
        if (in_xfer) begin
          case (in_opcode)
            cts_pkg::OP_ADD: begin
              push        = 1'b1;
              push_kind   = cts_pkg::KIND_ADD;
              push_slot   = 8'(count_r);
              push_handle = 8'd0;
              push_last   = 1'b1;
              if (count_r < MAX_CNT) begin
                push_acc                = 1'b1;
                mem_wr_en               = 1'b1;
                mem_wr_addr             = count_r[IDX_W-1:0];
                mem_wr_data.handle      = in_task_handle;
                mem_wr_data.due_at      = tick_r + cts_pkg::TICK_W'(in_start_delay);
                mem_wr_data.period      = in_repeat_period;
                count_nxt               = count_r + CNT_W'(1);
              end else begin
                push_acc = 1'b0;
              end
            end
            cts_pkg::OP_DELETE: begin
              push        = 1'b1;
              push_kind   = cts_pkg::KIND_DEL;
              push_slot   = in_delete_index;
              push_handle = 8'd0;
              push_acc    = del_ok;
              push_last   = 1'b1;
              if (del_ok) begin
                rd_nxt    = CNT_W'(in_delete_index) + CNT_W'(1);
                state_nxt = cts_pkg::ST_DEL_RD;
              end
            end
            cts_pkg::OP_TICK: begin
              tick_nxt = tick_r + cts_pkg::TICK_W'(1);
            end
            cts_pkg::OP_DISPATCH: begin
              rd_nxt         = '0;
              wr_nxt         = '0;
              pend_valid_nxt = 1'b0;
              state_nxt      = cts_pkg::ST_SCAN_RD;
            end
            default: begin
            end
          endcase
        end
      end

      cts_pkg::ST_SCAN_RD: begin
        if (rd_r == count_r) begin
          state_nxt = cts_pkg::ST_SCAN_END;
        end else begin
          mem_rd_en = 1'b1;
          state_nxt = cts_pkg::ST_SCAN_EV;
        end
      end

      cts_pkg::ST_SCAN_EV: begin
        // a due entry with a held result needs room in the result register
        if (!(due && pend_valid_r && !out_free)) begin
          if (due) begin
            push            = pend_valid_r;
            pend_valid_nxt  = 1'b1;
            pend_slot_nxt   = rd_r[IDX_W-1:0];
            pend_handle_nxt = mem_rd_data.handle;
          end
          // one-shot due tasks are dropped by not writing them back
          if (!(due && mem_rd_data.period == '0)) begin
            mem_wr_en = 1'b1;
            if (due) begin
              mem_wr_data.due_at = tick_r + cts_pkg::TICK_W'(mem_rd_data.period);
            end
            wr_nxt = wr_r + CNT_W'(1);
          end
          rd_nxt    = rd_r + CNT_W'(1);
          state_nxt = cts_pkg::ST_SCAN_RD;
        end
      end

      cts_pkg::ST_SCAN_END: begin
        if (!pend_valid_r || out_free) begin
          push           = pend_valid_r;
          push_last      = 1'b1;
          pend_valid_nxt = 1'b0;
          count_nxt      = wr_r;
          state_nxt      = cts_pkg::ST_IDLE;
        end
      end

      cts_pkg::ST_DEL_RD: begin
        if (rd_r == count_r) begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = cts_pkg::ST_IDLE;
        end else begin
          mem_rd_en = 1'b1;
          state_nxt = cts_pkg::ST_DEL_WR;
        end
      end

      cts_pkg::ST_DEL_WR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = rd_dec[IDX_W-1:0];
        rd_nxt      = rd_r + CNT_W'(1);
        state_nxt   = cts_pkg::ST_DEL_RD;
      end

      default: begin
        state_nxt = cts_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= cts_pkg::ST_IDLE;
      count_r      <= '0;
      tick_r       <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      tick_r       <= tick_nxt;
      pend_valid_r <= pend_valid_nxt;
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_r          <= rd_nxt;
    wr_r          <= wr_nxt;
    pend_slot_r   <= pend_slot_nxt;
    pend_handle_r <= pend_handle_nxt;
    if (push) begin
      out_kind_r   <= push_kind;
      out_slot_r   <= push_slot;
      out_handle_r <= push_handle;
      out_acc_r    <= push_acc;
      out_last_r   <= push_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_reply_kind  = out_kind_r;
  assign out_slot_index  = out_slot_r;
  assign out_run_handle  = out_handle_r;
  assign out_accepted    = out_acc_r;
  assign out_last_of_run = out_last_r;

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// self-checking testbench of the cooperative task scheduler core
module tb;

  localparam int SLOTS      = cts_pkg::MAX_TASKS_DEF;
  localparam int RANDOM_OPS = 300;
  localparam int CALM_FIRST = 120;
  localparam int CALM_LAST  = 200;
  localparam int PAUSE_AT   = 60;

  typedef struct packed {
    cts_pkg::kind_t kind;
    logic [7:0]     slot;
    logic [7:0]     handle;
    logic           acc;
    logic           last;
  } sched_reply_t;

  typedef struct packed {
    cts_pkg::op_t op;
    logic [7:0]   handle;
    logic [31:0]  delay;
    logic [31:0]  period;
    logic [7:0]   del_idx;
    logic         typed;
    logic [7:0]   exp_slot;
    logic         exp_acc;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_opcode = cts_pkg::OP_TICK;
  logic [7:0]  in_task_handle = 8'h00;
  logic [31:0] in_start_delay = 32'd0;
  logic [31:0] in_repeat_period = 32'd0;
  logic [7:0]  in_delete_index = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_reply_kind;
  logic [7:0]  out_slot_index;
  logic [7:0]  out_run_handle;
  logic        out_accepted;
  logic        out_last_of_run;

  // scheduler state as the testbench sees it
  logic [7:0]   task_handles [SLOTS];
  logic [63:0]  run_at [SLOTS];
  logic [31:0]  run_period [SLOTS];
  int unsigned  task_total = 0;
  logic [63:0]  ticks = 64'd0;
  sched_reply_t pending_replies [$];

  bit          calm = 1'b0;
  int unsigned ops_seen [4] = '{default: 0};
  int unsigned refused_adds = 0;
  int unsigned biggest_burst = 0;
  int unsigned replies_checked = 0;
  int unsigned mismatches = 0;

  // opening rows: empty table, field extremes, full table, bad deletes, one-shot runs
  stim_row_t directed [22] = '{
    '{cts_pkg::OP_DISPATCH, 8'h00, 32'd0, 32'd0, 8'd0, 1'b0, 8'd0, 1'b0},
    '{cts_pkg::OP_DELETE, 8'h00, 32'd0, 32'd0, 8'd0, 1'b1, 8'd0, 1'b0},
    '{cts_pkg::OP_ADD, 8'h00, 32'd0, 32'd0, 8'd0, 1'b1, 8'd0, 1'b1},
    '{cts_pkg::OP_ADD, 8'hff, 32'hffff_ffff, 32'hffff_ffff, 8'hff, 1'b1, 8'd1, 1'b1},
    '{cts_pkg::OP_ADD, 8'ha5, 32'd1, 32'd1, 8'd0, 1'b1, 8'd2, 1'b1},
    '{cts_pkg::OP_ADD, 8'h5a, 32'd0, 32'd2, 8'd0, 1'b1, 8'd3, 1'b1},
    '{cts_pkg::OP_DISPATCH, 8'h00, 32'd0, 32'd0, 8'd0, 1'b0, 8'd0, 1'b0},
    '{cts_pkg::OP_TICK, 8'h00, 32'd0, 32'd0, 8'd0, 1'b0, 8'd0, 1'b0},
    '{cts_pkg::OP_DISPATCH, 8'h00, 32'd0, 32'd0, 8'd0, 1'b0, 8'd0, 1'b0},
    '{cts_pkg::OP_ADD, 8'h11, 32'd0, 32'd0, 8'd0, 1'b0, 8'd0, 1'b0},
    '{cts_pkg::OP_ADD, 8'h22, 32'd0, 32'd0, 8'd0, 1'b0, 8'd0, 1'b0},
    '{cts_pkg::OP_ADD, 8'h33, 32'd0, 32'd0, 8'd0, 1'b0, 8'd0, 1'b0},
    '{cts_pkg::OP_ADD, 8'h44, 32'd0, 32'd0, 8'd0, 1'b0, 8'd0, 1'b0},
    '{cts_pkg::OP_ADD, 8'h55, 32'd0, 32'd0, 8'd0, 1'b0, 8'd0, 1'b0},
    '{cts_pkg::OP_ADD, 8'h77, 32'd3, 32'd3, 8'd0, 1'b1, 8'd8, 1'b0},
    '{cts_pkg::OP_DELETE, 8'h00, 32'd0, 32'd0, 8'd255, 1'b1, 8'd255, 1'b0},
    '{cts_pkg::OP_DELETE, 8'h00, 32'd0, 32'd0, 8'd8, 1'b1, 8'd8, 1'b0},
    '{cts_pkg::OP_DELETE, 8'h00, 32'd0, 32'd0, 8'd7, 1'b1, 8'd7, 1'b1},
    '{cts_pkg::OP_DELETE, 8'h00, 32'd0, 32'd0, 8'd0, 1'b1, 8'd0, 1'b1},
    '{cts_pkg::OP_DISPATCH, 8'h00, 32'd0, 32'd0, 8'd0, 1'b0, 8'd0, 1'b0},
    '{cts_pkg::OP_TICK, 8'h00, 32'd0, 32'd0, 8'd0, 1'b0, 8'd0, 1'b0},
    '{cts_pkg::OP_DISPATCH, 8'h00, 32'd0, 32'd0, 8'd0, 1'b0, 8'd0, 1'b0}
  };

  cooperative_task_scheduler_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_task_handle   (in_task_handle),
    .in_start_delay   (in_start_delay),
    .in_repeat_period (in_repeat_period),
    .in_delete_index  (in_delete_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_reply_kind   (out_reply_kind),
    .out_slot_index   (out_slot_index),
    .out_run_handle   (out_run_handle),
    .out_accepted     (out_accepted),
    .out_last_of_run  (out_last_of_run)
  );

  always begin
    #5;
    clk = 1'b1;
    #5;
    clk = 1'b0;
  end

  function automatic void remove_task(input int unsigned pos);
    for (int unsigned k = pos; k + 1 < task_total; k++) begin
      task_handles[k] = task_handles[k + 1];
      run_at[k]       = run_at[k + 1];
      run_period[k]   = run_period[k + 1];
    end
    task_total--;
  endfunction

  // applies one operation to the tracked state and queues the replies it causes
  function automatic void schedule_op(input stim_row_t row);
    sched_reply_t found [$];
    sched_reply_t r;
    int unsigned  i;
    int unsigned  pos;
    case (row.op)
      cts_pkg::OP_ADD: begin
        r = '{cts_pkg::KIND_ADD, 8'(task_total), 8'h00, 1'b0, 1'b0};
        if (task_total < SLOTS) begin
          task_handles[task_total] = row.handle;
          run_at[task_total]       = ticks + 64'(row.delay);
          run_period[task_total]   = row.period;
          task_total++;
          r.acc = 1'b1;
        end else begin
          refused_adds++;
        end
        found.push_back(r);
      end
      cts_pkg::OP_DELETE: begin
        r = '{cts_pkg::KIND_DEL, row.del_idx, 8'h00, 1'b0, 1'b0};
        if (32'(row.del_idx) < task_total) begin
          remove_task(32'(row.del_idx));
          r.acc = 1'b1;
        end
        found.push_back(r);
      end
      cts_pkg::OP_TICK: ticks++;
      default: begin
        i = 0;
        pos = 0;
        // a dropped one-shot pulls the next entry into slot i, which is examined next
        while (i < task_total) begin
          if (ticks >= run_at[i]) begin
            r = '{cts_pkg::KIND_RUN, 8'(pos), task_handles[i], 1'b1, 1'b0};
            found.push_back(r);
          end
          if (ticks >= run_at[i] && run_period[i] == 32'd0) begin
            remove_task(i);
          end else begin
            if (ticks >= run_at[i]) run_at[i] = ticks + 64'(run_period[i]);
            i++;
          end
          pos++;
        end
        if (found.size() > biggest_burst) biggest_burst = found.size();
      end
    endcase
    if (found.size() > 0) begin
      r = found.pop_back();
      r.last = 1'b1;
      found.push_back(r);
    end
    if (row.typed) begin
      found.delete();
      r.kind = (row.op == cts_pkg::OP_ADD) ? cts_pkg::KIND_ADD : cts_pkg::KIND_DEL;
      r.slot   = row.exp_slot;
      r.handle = 8'h00;
      r.acc    = row.exp_acc;
      r.last   = 1'b1;
      found.push_back(r);
    end
    foreach (found[k]) pending_replies.push_back(found[k]);
  endfunction

  function automatic stim_row_t random_row();
    stim_row_t   row;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    row.handle   = 8'($urandom);
    row.delay    = $urandom;
    row.period   = $urandom;
    row.del_idx  = 8'($urandom);
    row.typed    = 1'b0;
    row.exp_slot = 8'd0;
    row.exp_acc  = 1'b0;
    if (pick < 30) begin
      row.op = cts_pkg::OP_ADD;
      // mostly short delays and periods so tasks actually come due
      if ($urandom_range(0, 15) != 0) row.delay = $urandom_range(0, 6);
      if ($urandom_range(0, 15) != 0) begin
        row.period = ($urandom_range(0, 2) == 0) ? 32'd0 : 32'($urandom_range(1, 4));
      end
    end else if (pick < 45) begin
      row.op = cts_pkg::OP_DELETE;
      if ($urandom_range(0, 7) != 0) row.del_idx = 8'($urandom_range(0, task_total));
    end else if (pick < 72) begin
      row.op = cts_pkg::OP_TICK;
    end else begin
      row.op = cts_pkg::OP_DISPATCH;
    end
    return row;
  endfunction

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_op(input stim_row_t row);
    while (!calm && $urandom_range(0, 99) < 8) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_opcode        <= row.op;
    in_task_handle   <= row.handle;
    in_start_delay   <= row.delay;
    in_repeat_period <= row.period;
    in_delete_index  <= row.del_idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    schedule_op(row);
    ops_seen[row.op]++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_replies.size() != 0) @(negedge clk);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    $display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
  endtask

  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 8);
  end

  always @(posedge clk) begin
    sched_reply_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("result with nothing pending", 64'(out_slot_index), 64'd0);
      end else begin
        want = pending_replies.pop_front();
        replies_checked++;
        if (out_reply_kind != want.kind)
          report_mismatch("reply_kind", 64'(out_reply_kind), 64'(want.kind));
        if (out_slot_index != want.slot)
          report_mismatch("slot_index", 64'(out_slot_index), 64'(want.slot));
        if (out_run_handle != want.handle)
          report_mismatch("run_handle", 64'(out_run_handle), 64'(want.handle));
        if (out_accepted != want.acc)
          report_mismatch("accepted", 64'(out_accepted), 64'(want.acc));
        if (out_last_of_run != want.last)
          report_mismatch("last_of_run", 64'(out_last_of_run), 64'(want.last));
      end
    end
  end

  initial begin
    stim_row_t row;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    foreach (directed[k]) send_op(directed[k]);
    for (int n = 0; n < RANDOM_OPS; n++) begin
      calm = (n >= CALM_FIRST && n < CALM_LAST);
      // hold the sender until the scheduler has emptied its output
      if (n == PAUSE_AT) drain();
      row = random_row();
      send_op(row);
    end
    calm = 1'b0;
    drain();
    repeat (40) @(posedge clk);
    $display("covered %0d adds (%0d refused), %0d deletes, %0d ticks, %0d dispatches",
             ops_seen[cts_pkg::OP_ADD], refused_adds, ops_seen[cts_pkg::OP_DELETE],
             ops_seen[cts_pkg::OP_TICK], ops_seen[cts_pkg::OP_DISPATCH]);
    $display("%0d results compared, longest dispatch burst %0d", replies_checked,
             biggest_burst);
    if (mismatches == 0 && pending_replies.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
